// ===== rtl/fsp_pkg.sv =====
// Package for the file-spec parser: phase codes, state and result types,
// character constants and character-class helpers.
// Depends on nothing; used by fsp_step, file_spec_parser_top and tb.
`default_nettype none

package fsp_pkg;

    localparam int NAME_CHARS = 6;
    localparam int EXT_CHARS  = 3;
    localparam int MAX_CHARS  = (NAME_CHARS > EXT_CHARS) ? NAME_CHARS : EXT_CHARS;
    localparam int CNT_W      = $clog2(MAX_CHARS + 1);
    localparam int NAME_W     = 8 * NAME_CHARS;
    localparam int EXT_W      = 8 * EXT_CHARS;
    localparam int FLAG_W     = 7;

    // flag bit positions
    localparam int FL_PAIR  = 0;
    localparam int FL_PAIRW = 1;
    localparam int FL_NAME  = 2;
    localparam int FL_NAMEW = 3;
    localparam int FL_EXT   = 4;
    localparam int FL_EXTW  = 5;
    localparam int FL_PROT  = 6;

    // characters
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;

    // numbers
    localparam logic [7:0] NUM_MAX   = 8'd254;
    localparam logic [7:0] NUM_WILD  = 8'd255;
    localparam logic [7:0] DEF_PROJ  = 8'd1;
    localparam logic [7:0] DEF_PROG  = 8'd2;
    localparam logic [7:0] PROG_BANG = 8'd3;
    localparam logic [7:0] PROG_PCT  = 8'd4;
    localparam logic [7:0] PROG_AMP  = 8'd5;

    typedef enum logic [3:0] {
        PH_START,
        PH_PROJ_FIRST,
        PH_PROJ_NUM,
        PH_PROJ_SEP,
        PH_PROG_FIRST,
        PH_PROG_NUM,
        PH_PROG_END,
        PH_NAME,
        PH_EXT,
        PH_PROT_FIRST,
        PH_PROT_NUM,
        PH_DONE
    } phase_t;

    typedef struct packed {
        phase_t                      phase;
        logic [7:0]                  num;
        logic [7:0]                  project;
        logic [7:0]                  programmer;
        logic [NAME_CHARS-1:0][7:0]  name_buf;
        logic [EXT_CHARS-1:0][7:0]   ext_buf;
        logic [CNT_W-1:0]            cnt;
        logic [FLAG_W-1:0]           flags;
        logic [7:0]                  prot;
        logic                        err;
    } fsp_state_t;

    typedef struct packed {
        logic               ok;
        logic [7:0]         project;
        logic [7:0]         programmer;
        logic [NAME_W-1:0]  name_text;
        logic [EXT_W-1:0]   ext_text;
        logic [FLAG_W-1:0]  flags;
        logic [7:0]         prot;
    } fsp_result_t;

    localparam fsp_state_t STATE_RESET = '{
        phase:      PH_START,
        num:        8'd0,
        project:    8'd0,
        programmer: 8'd0,
        name_buf:   {NAME_CHARS{CH_SPACE}},
        ext_buf:    {EXT_CHARS{CH_SPACE}},
        cnt:        '0,
        flags:      '0,
        prot:       8'd0,
        err:        1'b0
    };

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_upper(input logic [7:0] c);
        return (c >= CH_UP_A) && (c <= CH_UP_Z);
    endfunction

    function automatic logic is_lower(input logic [7:0] c);
        return (c >= CH_LO_A) && (c <= CH_LO_Z);
    endfunction

    function automatic logic is_part_char(input logic [7:0] c);
        return is_digit(c) || is_upper(c) || is_lower(c) ||
               (c == CH_SPACE) || (c == CH_QMARK) || (c == CH_STAR);
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return is_upper(c) ? (c | 8'h20) : c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/file_spec_parser_top.sv =====
// Top level of the file-spec parser: input register, parse state, result register.
// Depends on fsp_pkg and fsp_step.
//
// Usage:
//   Input channel (in_valid / in_stall / char_code) carries one character per
//   item. A character of 0 ends the spec; only that item produces a result.
//   Output channel (out_valid / out_stall / ok ... protection) carries one
//   result item per spec. ok = 0 flags a malformed spec and then every other
//   field is 0.
// Result path: a terminator passes through the input register, then the result
//   register, which takes it once no result is held under out_stall.
// Throughput: one character per cycle unless a result is held under out_stall;
//   the parse state is updated by a single pass of character-class and
//   multiply-by-ten logic between the input register and the state/result registers.
// Stall: a pending result held under out_stall freezes the input register,
//   and in_stall rises once that register is also occupied; nothing is lost
//   or repeated. The result register keeps its payload while stalled.
// Reset: rst_n (asynchronous, active low) empties both registers and puts
//   the parser at the start of a spec. After each terminator the parser
//   returns to that same start state for the next spec.
`default_nettype none

module file_spec_parser_top
    import fsp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,

    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [7:0]        char_code,

    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic                   ok,
    output logic [7:0]             project,
    output logic [7:0]             programmer,
    output logic [NAME_W-1:0]      name_text,
    output logic [EXT_W-1:0]       ext_text,
    output logic [FLAG_W-1:0]      spec_flags,
    output logic [7:0]             protection
);

    logic [7:0]  char_reg;
    logic        char_vld_reg;
    logic        char_vld_next;
    fsp_state_t  state_reg;
    fsp_state_t  state_next;
    fsp_result_t res_reg;
    fsp_result_t res_calc;
    logic        out_vld_reg;
    logic        out_vld_next;

    logic        in_take;
    logic        blocked;
    logic        fire;
    logic        fire_term;

    // hold the character stage while a finished result waits downstream
    assign blocked   = out_vld_reg && out_stall;
    assign fire      = char_vld_reg && !blocked;
    assign fire_term = fire && (char_reg == CH_NUL);
    assign in_stall  = char_vld_reg && blocked;
    assign in_take   = in_valid && !in_stall;

    fsp_step u_step (
        .cur (state_reg),
        .ch  (char_reg),
        .nxt (state_next),
        .res (res_calc)
    );

    always_comb
    begin
        char_vld_next = char_vld_reg;
        if (in_take) begin
            char_vld_next = 1'b1;
        end else if (fire) begin
            char_vld_next = 1'b0;
        end
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (fire_term) begin
            out_vld_next = 1'b1;
        end else if (out_vld_reg && !out_stall) begin
            out_vld_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            char_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
            state_reg    <= STATE_RESET;
        end else begin
            char_vld_reg <= char_vld_next;
            out_vld_reg  <= out_vld_next;
            if (fire) begin
                state_reg <= state_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take) begin
            char_reg <= char_code;
        end
        if (fire_term) begin
            res_reg <= res_calc;
        end
    end

    assign out_valid  = out_vld_reg;
    assign ok         = res_reg.ok;
    assign project    = res_reg.project;
    assign programmer = res_reg.programmer;
    assign name_text  = res_reg.name_text;
    assign ext_text   = res_reg.ext_text;
    assign spec_flags = res_reg.flags;
    assign protection = res_reg.prot;

endmodule

`default_nettype wire

// ===== rtl/fsp_step.sv =====
// Per-character update of the file-spec parser: next state and result.
// Pure combinational; uses fsp_pkg.
`default_nettype none

module fsp_step
    import fsp_pkg::*;
(
    input  fsp_state_t  cur,
    input  logic [7:0]  ch,
    output fsp_state_t  nxt,
    output fsp_result_t res
);

    logic [11:0]                acc_sum;
    logic [7:0]                 acc_val;
    logic [7:0]                 digit_val;
    logic                       is_sep;
    logic                       is_close;

    logic [NAME_CHARS-1:0][7:0] name_upd_buf;
    logic [CNT_W-1:0]           name_upd_cnt;
    logic                       name_upd_wild;
    logic [EXT_CHARS-1:0][7:0]  ext_upd_buf;
    logic [CNT_W-1:0]           ext_upd_cnt;
    logic                       ext_upd_wild;

    fsp_state_t                 name_nxt;
    fsp_state_t                 fin;

    // decimal accumulate, saturating at 255
    assign digit_val = {4'd0, ch[3:0]};
    assign acc_sum   = {4'd0, cur.num} * 12'd10 + {4'd0, digit_val};
    assign acc_val   = (acc_sum > 12'd255) ? NUM_WILD : acc_sum[7:0];
    assign is_sep    = (ch == CH_COMMA) || (ch == CH_SLASH);
    assign is_close  = (ch == CH_RBRACK) || (ch == CH_RPAREN) || (ch == CH_SLASH);

    // name character update
    always_comb
    begin
        name_upd_buf  = cur.name_buf;
        name_upd_cnt  = cur.cnt;
        name_upd_wild = 1'b0;
        if (ch == CH_STAR) begin
            if (cur.cnt < CNT_W'(NAME_CHARS)) begin
                for (int i = 0; i < NAME_CHARS; i++) begin
                    if (CNT_W'(i) >= cur.cnt) begin
                        name_upd_buf[NAME_CHARS-1-i] = CH_QMARK;
                    end
                end
                name_upd_cnt  = CNT_W'(NAME_CHARS);
                name_upd_wild = 1'b1;
            end
        end else if (ch != CH_SPACE) begin
            if (cur.cnt < CNT_W'(NAME_CHARS)) begin
                for (int i = 0; i < NAME_CHARS; i++) begin
                    if (CNT_W'(i) == cur.cnt) begin
                        name_upd_buf[NAME_CHARS-1-i] = to_lower(ch);
                    end
                end
                name_upd_cnt = cur.cnt + 1'b1;
            end
            name_upd_wild = (ch == CH_QMARK);
        end
    end

    // extension character update
    always_comb
    begin
        ext_upd_buf  = cur.ext_buf;
        ext_upd_cnt  = cur.cnt;
        ext_upd_wild = 1'b0;
        if (ch == CH_STAR) begin
            if (cur.cnt < CNT_W'(EXT_CHARS)) begin
                for (int i = 0; i < EXT_CHARS; i++) begin
                    if (CNT_W'(i) >= cur.cnt) begin
                        ext_upd_buf[EXT_CHARS-1-i] = CH_QMARK;
                    end
                end
                ext_upd_cnt  = CNT_W'(EXT_CHARS);
                ext_upd_wild = 1'b1;
            end
        end else if (ch != CH_SPACE) begin
            if (cur.cnt < CNT_W'(EXT_CHARS)) begin
                for (int i = 0; i < EXT_CHARS; i++) begin
                    if (CNT_W'(i) == cur.cnt) begin
                        ext_upd_buf[EXT_CHARS-1-i] = to_lower(ch);
                    end
                end
                ext_upd_cnt = cur.cnt + 1'b1;
            end
            ext_upd_wild = (ch == CH_QMARK);
        end
    end

    // name-phase handling, shared by the start and name phases;
    // the start phase gets the default pair, the name phase keeps its own
    always_comb
    begin
        name_nxt            = cur;
        name_nxt.project    = DEF_PROJ;
        name_nxt.programmer = DEF_PROG;
        name_nxt.phase      = PH_NAME;
        if (cur.phase == PH_NAME) begin
            name_nxt.project    = cur.project;
            name_nxt.programmer = cur.programmer;
        end
        if (is_part_char(ch)) begin
            name_nxt.name_buf = name_upd_buf;
            name_nxt.cnt      = name_upd_cnt;
            if (ch != CH_SPACE) begin
                name_nxt.flags[FL_NAME] = 1'b1;
            end
            if (name_upd_wild) begin
                name_nxt.flags[FL_NAMEW] = 1'b1;
            end
        end else if (ch == CH_DOT) begin
            name_nxt.flags[FL_EXT] = 1'b1;
            name_nxt.cnt           = '0;
            name_nxt.phase         = PH_EXT;
        end else if (ch == CH_LT) begin
            name_nxt.flags[FL_PROT] = 1'b1;
            name_nxt.phase          = PH_PROT_FIRST;
        end else begin
            name_nxt.err = 1'b1;
        end
    end

    // next state: back to the reset state at the terminator, else the per-phase update
    always_comb
    begin
        nxt = cur;
        if (ch == CH_NUL) begin
            nxt = STATE_RESET;
        end else if (!cur.err) begin
            unique case (cur.phase)
                PH_START:
                begin
                    if ((ch == CH_LBRACK) || (ch == CH_LPAREN) || (ch == CH_SLASH)) begin
                        nxt.flags[FL_PAIR] = 1'b1;
                        nxt.phase          = PH_PROJ_FIRST;
                    end else if ((ch == CH_DOLLAR) || (ch == CH_BANG) ||
                                 (ch == CH_PCT) || (ch == CH_AMP)) begin
                        nxt.flags[FL_PAIR] = 1'b1;
                        nxt.project        = DEF_PROJ;
                        nxt.phase          = PH_NAME;
                        case (ch)
                            CH_DOLLAR: nxt.programmer = DEF_PROG;
                            CH_BANG:   nxt.programmer = PROG_BANG;
                            CH_PCT:    nxt.programmer = PROG_PCT;
                            default:   nxt.programmer = PROG_AMP;
                        endcase
                    end else begin
                        nxt = name_nxt;
                    end
                end
                PH_PROJ_FIRST:
                begin
                    if (ch == CH_STAR) begin
                        nxt.project         = NUM_WILD;
                        nxt.flags[FL_PAIRW] = 1'b1;
                        nxt.phase           = PH_PROJ_SEP;
                    end else if (is_digit(ch)) begin
                        nxt.num   = digit_val;
                        nxt.phase = PH_PROJ_NUM;
                    end else begin
                        nxt.err = 1'b1;
                    end
                end
                PH_PROJ_NUM:
                begin
                    if (is_digit(ch)) begin
                        nxt.num = acc_val;
                    end else if (cur.num > NUM_MAX) begin
                        nxt.err = 1'b1;
                    end else if (is_sep) begin
                        nxt.project = cur.num;
                        nxt.phase   = PH_PROG_FIRST;
                    end else begin
                        nxt.err = 1'b1;
                    end
                end
                PH_PROJ_SEP:
                begin
                    if (is_sep) begin
                        nxt.phase = PH_PROG_FIRST;
                    end else begin
                        nxt.err = 1'b1;
                    end
                end
                PH_PROG_FIRST:
                begin
                    if (ch == CH_STAR) begin
                        nxt.programmer      = NUM_WILD;
                        nxt.flags[FL_PAIRW] = 1'b1;
                        nxt.phase           = PH_PROG_END;
                    end else if (is_digit(ch)) begin
                        nxt.num   = digit_val;
                        nxt.phase = PH_PROG_NUM;
                    end else begin
                        nxt.err = 1'b1;
                    end
                end
                PH_PROG_NUM:
                begin
                    if (is_digit(ch)) begin
                        nxt.num = acc_val;
                    end else if (cur.num > NUM_MAX) begin
                        nxt.err = 1'b1;
                    end else begin
                        nxt.programmer = cur.num;
                        if ((cur.project == 8'd0) && (cur.num == 8'd0)) begin
                            nxt.err = 1'b1;
                        end else if (is_close) begin
                            nxt.phase = PH_NAME;
                        end else begin
                            nxt.err = 1'b1;
                        end
                    end
                end
                PH_PROG_END:
                begin
                    if (is_close) begin
                        nxt.phase = PH_NAME;
                    end else begin
                        nxt.err = 1'b1;
                    end
                end
                PH_NAME:
                begin
                    nxt = name_nxt;
                end
                PH_EXT:
                begin
                    if (is_part_char(ch)) begin
                        nxt.ext_buf = ext_upd_buf;
                        nxt.cnt     = ext_upd_cnt;
                        if (ext_upd_wild) begin
                            nxt.flags[FL_EXTW] = 1'b1;
                        end
                    end else if (ch == CH_LT) begin
                        nxt.flags[FL_PROT] = 1'b1;
                        nxt.phase          = PH_PROT_FIRST;
                    end else begin
                        nxt.err = 1'b1;
                    end
                end
                PH_PROT_FIRST:
                begin
                    if (is_digit(ch)) begin
                        nxt.num   = digit_val;
                        nxt.phase = PH_PROT_NUM;
                    end else begin
                        nxt.err = 1'b1;
                    end
                end
                PH_PROT_NUM:
                begin
                    if (is_digit(ch)) begin
                        nxt.num = acc_val;
                    end else if (ch == CH_GT) begin
                        nxt.prot  = cur.num;
                        nxt.phase = PH_DONE;
                    end else begin
                        nxt.err = 1'b1;
                    end
                end
                default:
                begin
                    nxt.err = 1'b1;
                end
            endcase
        end
    end

    // finishing step at the terminator
    always_comb
    begin
        fin = cur;
        unique case (cur.phase)
            PH_START:
            begin
                fin.project    = DEF_PROJ;
                fin.programmer = DEF_PROG;
            end
            PH_PROG_NUM:
            begin
                if (cur.num > NUM_MAX) begin
                    fin.err = 1'b1;
                end else begin
                    fin.programmer = cur.num;
                    if ((cur.project == 8'd0) && (cur.num == 8'd0)) begin
                        fin.err = 1'b1;
                    end
                end
            end
            PH_PROG_END, PH_NAME, PH_EXT, PH_DONE:
            begin
                fin.err = cur.err;
            end
            default:
            begin
                fin.err = 1'b1;
            end
        endcase
    end

    // result: all zero on error
    always_comb
    begin
        res = '0;
        if (!fin.err) begin
            res.ok         = 1'b1;
            res.project    = fin.project;
            res.programmer = fin.programmer;
            res.name_text  = fin.name_buf;
            res.ext_text   = fin.ext_buf;
            res.flags      = fin.flags;
            res.prot       = fin.prot;
        end
    end

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the file-spec parser (file_spec_parser_top).
// Depends on fsp_pkg for widths, flag positions, character codes and the result type.
// Streams specs one character at a time and checks every result against a local parser.

module tb
    import fsp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;

    // ------------------------------------------------------------------
    // Clock, reset and the block's ports
    // ------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [7:0]        char_code = 8'h00;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic              ok;
    logic [7:0]        project;
    logic [7:0]        programmer;
    logic [NAME_W-1:0] name_text;
    logic [EXT_W-1:0]  ext_text;
    logic [FLAG_W-1:0] spec_flags;
    logic [7:0]        protection;

    always #6 clk = ~clk;

    file_spec_parser_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .char_code  (char_code),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .ok         (ok),
        .project    (project),
        .programmer (programmer),
        .name_text  (name_text),
        .ext_text   (ext_text),
        .spec_flags (spec_flags),
        .protection (protection)
    );

    // ------------------------------------------------------------------
    // Bookkeeping shared by the stimulus, driver and monitor
    // ------------------------------------------------------------------
    logic [7:0]  pending_chars[$];   // characters not yet presented to the block
    logic [7:0]  spec_buf[$];        // one random spec under construction
    fsp_result_t expected_specs[$];  // parse results still owed by the block
    fsp_result_t want;
    int          chars_queued = 0;
    int          chars_accepted = 0;
    int          specs_expected = 0;
    int          specs_seen = 0;
    int          mismatches = 0;
    int          cycles = 0;
    int          send_gap = 0;
    int          hold_left = 0;
    bit          idle_on = 1'b1;

    // ------------------------------------------------------------------
    // Local parser: its own copy of the parse state, advanced one
    // accepted character at a time.
    // ------------------------------------------------------------------
    phase_t            sp_phase;
    int                sp_num;
    logic [7:0]        sp_proj;
    logic [7:0]        sp_prog;
    logic [7:0]        sp_name[NAME_CHARS];
    logic [7:0]        sp_ext[EXT_CHARS];
    int                sp_cnt;
    logic [FLAG_W-1:0] sp_flags;
    logic [7:0]        sp_prot;
    bit                sp_err;

    function automatic bit num_char(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic bit upper_char(input logic [7:0] c);
        return c >= CH_UP_A && c <= CH_UP_Z;
    endfunction

    function automatic bit part_class(input logic [7:0] c);
        return num_char(c) || upper_char(c) || (c >= CH_LO_A && c <= CH_LO_Z) ||
               c == CH_SPACE || c == CH_QMARK || c == CH_STAR;
    endfunction

    function automatic bit closer_char(input logic [7:0] c);
        return c == CH_RBRACK || c == CH_RPAREN || c == CH_SLASH;
    endfunction

    task automatic clear_parse();
        int i;
        sp_phase = PH_START;
        sp_num   = 0;
        sp_proj  = 8'd0;
        sp_prog  = 8'd0;
        for (i = 0; i < NAME_CHARS; i++)
            sp_name[i] = CH_SPACE;
        for (i = 0; i < EXT_CHARS; i++)
            sp_ext[i] = CH_SPACE;
        sp_cnt   = 0;
        sp_flags = '0;
        sp_prot  = 8'd0;
        sp_err   = 1'b0;
    endtask

    // Decimal accumulation saturates at 255.
    task automatic add_digit(input logic [7:0] c);
        sp_num = sp_num * 10 + (int'(c) - int'(CH_ZERO));
        if (sp_num > 255)
            sp_num = 255;
    endtask

    // Store one name or extension character; blanks skip, * pads with ?.
    task automatic store_part(input logic [7:0] c, input bit in_ext);
        int         size;
        int         wild_bit;
        logic [7:0] lc;
        size     = in_ext ? EXT_CHARS : NAME_CHARS;
        wild_bit = in_ext ? FL_EXTW : FL_NAMEW;
        if (c == CH_STAR) begin
            if (sp_cnt < size)
                sp_flags[wild_bit] = 1'b1;
            while (sp_cnt < size) begin
                if (in_ext)
                    sp_ext[sp_cnt] = CH_QMARK;
                else
                    sp_name[sp_cnt] = CH_QMARK;
                sp_cnt++;
            end
        end else if (c != CH_SPACE) begin
            lc = upper_char(c) ? (c | 8'h20) : c;
            if (sp_cnt < size) begin
                if (in_ext)
                    sp_ext[sp_cnt] = lc;
                else
                    sp_name[sp_cnt] = lc;
                sp_cnt++;
            end
            // a ? past the end is dropped but still marks the part wild
            if (c == CH_QMARK)
                sp_flags[wild_bit] = 1'b1;
        end
    endtask

    task automatic name_step(input logic [7:0] c);
        if (part_class(c)) begin
            if (c != CH_SPACE)
                sp_flags[FL_NAME] = 1'b1;
            store_part(c, 1'b0);
        end else if (c == CH_DOT) begin
            sp_flags[FL_EXT] = 1'b1;
            sp_cnt   = 0;
            sp_phase = PH_EXT;
        end else if (c == CH_LT) begin
            sp_flags[FL_PROT] = 1'b1;
            sp_phase = PH_PROT_FIRST;
        end else begin
            sp_err = 1'b1;
        end
    endtask

    // Programmer number complete: range check and the both-zero rule.
    task automatic close_prog();
        if (sp_num > int'(NUM_MAX)) begin
            sp_err = 1'b1;
        end else begin
            sp_prog = 8'(sp_num);
            if (sp_proj == 8'd0 && sp_prog == 8'd0)
                sp_err = 1'b1;
        end
    endtask

    task automatic parse_char(input logic [7:0] c);
        fsp_result_t r;
        int          i;
        if (c == CH_NUL) begin
            case (sp_phase)
                PH_START: begin
                    sp_proj = DEF_PROJ;
                    sp_prog = DEF_PROG;
                end
                PH_PROG_NUM: close_prog();
                PH_PROG_END, PH_NAME, PH_EXT, PH_DONE: ;
                default: sp_err = 1'b1;
            endcase
            r = '0;
            if (!sp_err) begin
                r.ok         = 1'b1;
                r.project    = sp_proj;
                r.programmer = sp_prog;
                for (i = 0; i < NAME_CHARS; i++)
                    r.name_text[NAME_W-1-8*i -: 8] = sp_name[i];
                for (i = 0; i < EXT_CHARS; i++)
                    r.ext_text[EXT_W-1-8*i -: 8] = sp_ext[i];
                r.flags = sp_flags;
                r.prot  = sp_prot;
            end
            expected_specs.push_back(r);
            specs_expected++;
            clear_parse();
        end else if (!sp_err) begin
            case (sp_phase)
                PH_START: begin
                    if (c == CH_LBRACK || c == CH_LPAREN || c == CH_SLASH) begin
                        sp_flags[FL_PAIR] = 1'b1;
                        sp_phase = PH_PROJ_FIRST;
                    end else if (c == CH_DOLLAR || c == CH_BANG ||
                                 c == CH_PCT || c == CH_AMP) begin
                        sp_flags[FL_PAIR] = 1'b1;
                        sp_proj  = DEF_PROJ;
                        sp_prog  = (c == CH_DOLLAR) ? DEF_PROG :
                                   (c == CH_BANG)   ? PROG_BANG :
                                   (c == CH_PCT)    ? PROG_PCT  : PROG_AMP;
                        sp_phase = PH_NAME;
                    end else begin
                        sp_proj  = DEF_PROJ;
                        sp_prog  = DEF_PROG;
                        sp_phase = PH_NAME;
                        name_step(c);
                    end
                end
                PH_PROJ_FIRST: begin
                    if (c == CH_STAR) begin
                        sp_proj = NUM_WILD;
                        sp_flags[FL_PAIRW] = 1'b1;
                        sp_phase = PH_PROJ_SEP;
                    end else if (num_char(c)) begin
                        sp_num = 0;
                        add_digit(c);
                        sp_phase = PH_PROJ_NUM;
                    end else begin
                        sp_err = 1'b1;
                    end
                end
                PH_PROJ_NUM: begin
                    if (num_char(c))
                        add_digit(c);
                    else if (sp_num > int'(NUM_MAX))
                        sp_err = 1'b1;
                    else if (c == CH_COMMA || c == CH_SLASH) begin
                        sp_proj  = 8'(sp_num);
                        sp_phase = PH_PROG_FIRST;
                    end else
                        sp_err = 1'b1;
                end
                PH_PROJ_SEP: begin
                    if (c == CH_COMMA || c == CH_SLASH)
                        sp_phase = PH_PROG_FIRST;
                    else
                        sp_err = 1'b1;
                end
                PH_PROG_FIRST: begin
                    if (c == CH_STAR) begin
                        sp_prog = NUM_WILD;
                        sp_flags[FL_PAIRW] = 1'b1;
                        sp_phase = PH_PROG_END;
                    end else if (num_char(c)) begin
                        sp_num = 0;
                        add_digit(c);
                        sp_phase = PH_PROG_NUM;
                    end else begin
                        sp_err = 1'b1;
                    end
                end
                PH_PROG_NUM: begin
                    if (num_char(c)) begin
                        add_digit(c);
                    end else begin
                        // the character that ends the number must also close the pair
                        close_prog();
                        if (!sp_err) begin
                            if (closer_char(c))
                                sp_phase = PH_NAME;
                            else
                                sp_err = 1'b1;
                        end
                    end
                end
                PH_PROG_END: begin
                    if (closer_char(c))
                        sp_phase = PH_NAME;
                    else
                        sp_err = 1'b1;
                end
                PH_NAME: name_step(c);
                PH_EXT: begin
                    if (part_class(c))
                        store_part(c, 1'b1);
                    else if (c == CH_LT) begin
                        sp_flags[FL_PROT] = 1'b1;
                        sp_phase = PH_PROT_FIRST;
                    end else
                        sp_err = 1'b1;
                end
                PH_PROT_FIRST: begin
                    if (num_char(c)) begin
                        sp_num = 0;
                        add_digit(c);
                        sp_phase = PH_PROT_NUM;
                    end else begin
                        sp_err = 1'b1;
                    end
                end
                PH_PROT_NUM: begin
                    if (num_char(c))
                        add_digit(c);
                    else if (c == CH_GT) begin
                        sp_prot  = 8'(sp_num);
                        sp_phase = PH_DONE;
                    end else
                        sp_err = 1'b1;
                end
                // anything after a closed protection is leftover text
                default: sp_err = 1'b1;
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_char(input logic [7:0] c);
        pending_chars.push_back(c);
        chars_queued++;
    endtask

    task automatic queue_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            queue_char(s[i]);
        queue_char(CH_NUL);
    endtask

    // Append a pair number or protection value: mostly in range, some at
    // the 254/255 boundary, some far above it to hit saturation.
    task automatic add_number(input bit allow_star);
        int sel;
        int v;
        int p;
        sel = $urandom_range(0, 9);
        if (allow_star && sel == 0) begin
            spec_buf.push_back(CH_STAR);
            return;
        end
        case (sel)
            1:       v = 0;
            2, 3:    v = $urandom_range(0, 9);
            4:       v = $urandom_range(250, 260);
            5:       v = $urandom_range(255, 99999);
            default: v = $urandom_range(0, 254);
        endcase
        if ($urandom_range(0, 7) == 0)
            spec_buf.push_back(CH_ZERO);
        p = 1;
        while (p * 10 <= v)
            p *= 10;
        while (p > 0) begin
            spec_buf.push_back(CH_ZERO + 8'((v / p) % 10));
            p /= 10;
        end
    endtask

    // Append len characters from the name/extension alphabet.
    task automatic add_part(input int len);
        repeat (len) begin
            case ($urandom_range(0, 11))
                0, 1, 2: spec_buf.push_back(8'($urandom_range(CH_UP_A, CH_UP_Z)));
                3, 4, 5: spec_buf.push_back(8'($urandom_range(CH_LO_A, CH_LO_Z)));
                6, 7:    spec_buf.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
                8:       spec_buf.push_back(CH_SPACE);
                9, 10:   spec_buf.push_back(CH_QMARK);
                default: spec_buf.push_back(CH_STAR);
            endcase
        end
    endtask

    // Build one spec: mostly well-formed with random content, some with a
    // corrupted character or trailing junk, some pure noise.
    task automatic queue_random_spec();
        int kind;
        int i;
        spec_buf.delete();
        kind = $urandom_range(0, 11);
        if (kind == 0) begin
            repeat ($urandom_range(0, 8))
                spec_buf.push_back(8'($urandom_range(1, 255)));
        end else begin
            case ($urandom_range(0, 3))
                0: ;
                1: begin
                    case ($urandom_range(0, 3))
                        0: spec_buf.push_back(CH_DOLLAR);
                        1: spec_buf.push_back(CH_BANG);
                        2: spec_buf.push_back(CH_PCT);
                        default: spec_buf.push_back(CH_AMP);
                    endcase
                end
                default: begin
                    case ($urandom_range(0, 2))
                        0: spec_buf.push_back(CH_LBRACK);
                        1: spec_buf.push_back(CH_LPAREN);
                        default: spec_buf.push_back(CH_SLASH);
                    endcase
                    add_number(1'b1);
                    spec_buf.push_back($urandom_range(0, 1) ? CH_COMMA : CH_SLASH);
                    add_number(1'b1);
                    case ($urandom_range(0, 7))
                        0: ;
                        1, 2: spec_buf.push_back(CH_RBRACK);
                        3, 4: spec_buf.push_back(CH_RPAREN);
                        default: spec_buf.push_back(CH_SLASH);
                    endcase
                end
            endcase
            add_part($urandom_range(0, 8));
            if ($urandom_range(0, 1)) begin
                spec_buf.push_back(CH_DOT);
                add_part($urandom_range(0, 5));
            end
            if ($urandom_range(0, 3) == 0) begin
                spec_buf.push_back(CH_LT);
                if ($urandom_range(0, 7) != 0)
                    add_number(1'b0);
                if ($urandom_range(0, 7) != 0)
                    spec_buf.push_back(CH_GT);
            end
            if (kind == 1 && spec_buf.size() > 0)
                spec_buf[$urandom_range(0, spec_buf.size() - 1)] = 8'($urandom_range(1, 255));
            if (kind == 2)
                spec_buf.push_back(8'($urandom_range(1, 255)));
        end
        for (i = 0; i < spec_buf.size(); i++)
            queue_char(spec_buf[i]);
        queue_char(CH_NUL);
    endtask

    task automatic compare_field(input string field, input logic [63:0] exp_val,
                                 input logic [63:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t ns: %s mismatch: expected %0h, actual %0h",
                     $time, field, exp_val, act_val);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: present queued characters; hold the payload while stalled,
    // and insert idle bursts after accepted items when idling is enabled.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                parse_char(char_code);
                chars_accepted++;
            end
            if (!in_valid || !in_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (pending_chars.size() != 0) begin
                    char_code <= pending_chars.pop_front();
                    in_valid  <= 1'b1;
                    if (idle_on && $urandom_range(0, 5) == 0)
                        send_gap = $urandom_range(1, 10);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each accepted result against the oldest expectation;
    // drive out_stall in random bursts.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                specs_seen++;
                if (expected_specs.size() == 0) begin
                    $display("%0t ns: result with no spec pending: expected none, actual ok=%0b",
                             $time, ok);
                    mismatches++;
                end else begin
                    want = expected_specs.pop_front();
                    compare_field("ok", want.ok, ok);
                    compare_field("project", want.project, project);
                    compare_field("programmer", want.programmer, programmer);
                    compare_field("name_text", want.name_text, name_text);
                    compare_field("ext_text", want.ext_text, ext_text);
                    compare_field("spec_flags", want.flags, spec_flags);
                    compare_field("protection", want.prot, protection);
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                hold_left = $urandom_range(0, 9);
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: end the run if the block stops making progress.
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        clear_parse();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty spec (default pair), lone &, both pair numbers
        // zero, and a wild project with 254, upper case, * fill, ? in the
        // extension and a saturating protection.
        queue_text("");
        queue_text("&");
        queue_text("/0/0");
        queue_text("[*,254]Ab*.?<999>");

        // Random specs with idling on both sides.
        while (chars_queued < 400)
            queue_random_spec();

        // Hold off the sender until every result so far has drained.
        wait (chars_accepted == chars_queued);
        wait (specs_seen == specs_expected);
        @(negedge clk);

        while (chars_queued < 600)
            queue_random_spec();
        wait (chars_accepted == chars_queued);
        @(negedge clk);

        // Final stretch at full rate: no idling on either side.
        idle_on = 1'b0;
        while (chars_queued < 740)
            queue_random_spec();

        wait (chars_accepted == chars_queued);
        wait (specs_seen == specs_expected);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
